// File: rtl/nbfs_pkg.sv
package nbfs_pkg;

    // Longest frame, in bytes, before it is aborted as an overflow
    localparam int MAX_FRAME_LEN = 2048;
    // Byte counter width: holds MAX_FRAME_LEN itself
    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

    // Sync pairs and sentence markers
    localparam logic [7:0] SYNC_BIN_A  = 8'hAF;
    localparam logic [7:0] SYNC_BIN_B  = 8'h20;
    localparam logic [7:0] SYNC_NMEA_A = 8'h24;
    localparam logic [7:0] SYNC_NMEA_B = 8'h47;
    localparam logic [7:0] NMEA_STAR   = 8'h2A;
    localparam logic [7:0] PRINT_LO    = 8'd32;
    localparam logic [7:0] PRINT_HI    = 8'd126;

    // Binary frame: bytes beyond the declared payload length
    localparam logic [16:0] BIN_OVERHEAD = 17'd8;
    // Checksum bytes after the star of a sentence
    localparam logic [15:0] NMEA_TAIL = 16'd2;

    // Binary header positions
    localparam logic [CNT_W-1:0] POS_ID     = CNT_W'(3);
    localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(4);
    localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(5);

    // Position of the second sync byte and count after it
    localparam logic [10:0]      POS_START   = 11'd1;
    localparam logic [CNT_W-1:0] COUNT_START = CNT_W'(2);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_MESSAGE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NMEA = 2'd1,
        KIND_BIN  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        EV_IDLE     = 3'd0,
        EV_START    = 3'd1,
        EV_BODY     = 3'd2,
        EV_DONE     = 3'd3,
        EV_BADCHAR  = 3'd4,
        EV_TOOBIG   = 3'd5,
        EV_OVERFLOW = 3'd6
    } event_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [10:0] frame_pos;
        kind_t       frame_kind;
        event_t      event_res;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
    } result_t;

endpackage

// File: rtl/nbfs_core.sv
module nbfs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    output nbfs_pkg::result_t res
);

    nbfs_pkg::phase_t               phase_reg, phase_next;
    logic [7:0]                     prev_byte_reg, prev_byte_next;
    logic [nbfs_pkg::CNT_W-1:0]     byte_count_reg, byte_count_next;
    logic                           kind_is_nmea_reg, kind_is_nmea_next;
    logic [15:0]                    end_count_reg, end_count_next;
    logic [7:0]                     len_low_reg, len_low_next;
    logic [7:0]                     id_byte_reg, id_byte_next;

    logic [nbfs_pkg::CNT_W-1:0]     cnt_inc;
    logic [15:0]                    len_word;
    logic                           done;

    // Hold frame state; advance one byte per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= nbfs_pkg::PH_HUNT;
            prev_byte_reg    <= '0;
            byte_count_reg   <= '0;
            kind_is_nmea_reg <= 1'b0;
            end_count_reg    <= '0;
            len_low_reg      <= '0;
            id_byte_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            prev_byte_reg    <= prev_byte_next;
            byte_count_reg   <= byte_count_next;
            kind_is_nmea_reg <= kind_is_nmea_next;
            end_count_reg    <= end_count_next;
            len_low_reg      <= len_low_next;
            id_byte_reg      <= id_byte_next;
        end
    end

    assign cnt_inc  = byte_count_reg + nbfs_pkg::CNT_W'(1);
    assign len_word = {rx_byte, len_low_reg};

    // Next state and result for the current byte
    always_comb
    begin
        phase_next        = phase_reg;
        prev_byte_next    = prev_byte_reg;
        byte_count_next   = byte_count_reg;
        kind_is_nmea_next = kind_is_nmea_reg;
        end_count_next    = end_count_reg;
        len_low_next      = len_low_reg;
        id_byte_next      = id_byte_reg;
        done              = 1'b0;

        res.data_byte   = rx_byte;
        res.frame_pos   = '0;
        res.frame_kind  = nbfs_pkg::KIND_NONE;
        res.event_res   = nbfs_pkg::EV_IDLE;
        res.msg_id      = '0;
        res.payload_len = '0;

        case (phase_reg)
            nbfs_pkg::PH_HEADER:
            begin
                res.frame_pos   = 11'(byte_count_reg);
                res.frame_kind  = kind_is_nmea_reg ? nbfs_pkg::KIND_NMEA : nbfs_pkg::KIND_BIN;
                res.event_res   = nbfs_pkg::EV_BODY;
                byte_count_next = cnt_inc;
                if (kind_is_nmea_reg)
                begin
                    // Sentence header: printable bytes only, up to the star
                    if (!(rx_byte inside {[nbfs_pkg::PRINT_LO:nbfs_pkg::PRINT_HI]}))
                    begin
                        res.event_res = nbfs_pkg::EV_BADCHAR;
                        phase_next    = nbfs_pkg::PH_HUNT;
                    end
                    else if (cnt_inc >= nbfs_pkg::CNT_W'(nbfs_pkg::MAX_FRAME_LEN))
                    begin
                        res.event_res = nbfs_pkg::EV_OVERFLOW;
                        phase_next    = nbfs_pkg::PH_HUNT;
                    end
                    else if (rx_byte == nbfs_pkg::NMEA_STAR)
                    begin
                        end_count_next = 16'(cnt_inc) + nbfs_pkg::NMEA_TAIL;
                        phase_next     = nbfs_pkg::PH_MESSAGE;
                    end
                end
                else
                begin
                    // Binary header: capture id and length
                    if (byte_count_reg == nbfs_pkg::POS_ID)
                    begin
                        id_byte_next = rx_byte;
                    end
                    else if (byte_count_reg == nbfs_pkg::POS_LEN_LO)
                    begin
                        len_low_next = rx_byte;
                    end
                    else if (byte_count_reg == nbfs_pkg::POS_LEN_HI)
                    begin
                        end_count_next  = len_word;
                        res.payload_len = len_word;
                        if (len_word > 16'(nbfs_pkg::MAX_FRAME_LEN))
                        begin
                            res.event_res = nbfs_pkg::EV_TOOBIG;
                            phase_next    = nbfs_pkg::PH_HUNT;
                        end
                        else
                        begin
                            phase_next = nbfs_pkg::PH_MESSAGE;
                        end
                    end
                end
            end

            nbfs_pkg::PH_MESSAGE:
            begin
                res.frame_pos   = 11'(byte_count_reg);
                res.frame_kind  = kind_is_nmea_reg ? nbfs_pkg::KIND_NMEA : nbfs_pkg::KIND_BIN;
                res.event_res   = nbfs_pkg::EV_BODY;
                byte_count_next = cnt_inc;
                if (kind_is_nmea_reg)
                begin
                    done = (16'(cnt_inc) >= end_count_reg);
                end
                else
                begin
                    res.payload_len = end_count_reg;
                    done = (17'(cnt_inc) == ({1'b0, end_count_reg} + nbfs_pkg::BIN_OVERHEAD));
                end
                // Completion wins over overflow
                if (done)
                begin
                    res.event_res = nbfs_pkg::EV_DONE;
                    phase_next    = nbfs_pkg::PH_HUNT;
                    if (!kind_is_nmea_reg)
                    begin
                        res.msg_id = id_byte_reg;
                    end
                end
                else if (cnt_inc >= nbfs_pkg::CNT_W'(nbfs_pkg::MAX_FRAME_LEN))
                begin
                    res.event_res = nbfs_pkg::EV_OVERFLOW;
                    phase_next    = nbfs_pkg::PH_HUNT;
                end
            end

            default:
            begin
                // Hunt for a sync pair
                prev_byte_next = rx_byte;
                phase_next     = nbfs_pkg::PH_HUNT;
                if ((prev_byte_reg == nbfs_pkg::SYNC_BIN_A && rx_byte == nbfs_pkg::SYNC_BIN_B) ||
                    (prev_byte_reg == nbfs_pkg::SYNC_NMEA_A && rx_byte == nbfs_pkg::SYNC_NMEA_B))
                begin
                    kind_is_nmea_next = (prev_byte_reg == nbfs_pkg::SYNC_NMEA_A);
                    phase_next        = nbfs_pkg::PH_HEADER;
                    byte_count_next   = nbfs_pkg::COUNT_START;
                    res.frame_pos     = nbfs_pkg::POS_START;
                    res.frame_kind    = (prev_byte_reg == nbfs_pkg::SYNC_NMEA_A) ?
                                        nbfs_pkg::KIND_NMEA : nbfs_pkg::KIND_BIN;
                    res.event_res     = nbfs_pkg::EV_START;
                end
            end
        endcase
    end

endmodule

// File: rtl/nmea_binary_frame_sync.sv
// Frame finder for a mixed byte stream of binary frames (sync 0xAF 0x20, little-endian
// payload length in bytes 4 and 5, frame of length+8 bytes) and NMEA sentences
// (sync '$' 'G', printable bytes up to '*', then two checksum bytes). Every accepted
// byte yields exactly one result carrying the byte, its position in the frame, the
// frame kind, an event code and, on a binary completion, the message id. The block
// takes one byte per clock while the output does not stall: a byte passes an input
// register, the combinational frame state logic and a result register. While a result
// waits on a stalled output, the input register takes at most one more byte and then
// stalls the input until the result is taken.
module nmea_binary_frame_sync (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [10:0] frame_pos,
    output logic [1:0]  frame_kind,
    output logic [2:0]  event_res,
    output logic [7:0]  msg_id,
    output logic [15:0] payload_len
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg;
    nbfs_pkg::result_t  res_reg;
    nbfs_pkg::result_t  res_comb;
    logic               out_busy;
    logic               fire;

    assign out_busy = out_valid_reg && out_stall;
    assign fire     = in_valid_reg && !out_busy;
    assign in_stall = in_valid_reg && out_busy;

    // Hold the input byte until the frame logic takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    nbfs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .res     (res_comb)
    );

    // Register the result; hold it while the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_busy)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = res_reg.data_byte;
    assign frame_pos   = res_reg.frame_pos;
    assign frame_kind  = res_reg.frame_kind;
    assign event_res   = res_reg.event_res;
    assign msg_id      = res_reg.msg_id;
    assign payload_len = res_reg.payload_len;

`ifndef SYNTHESIS
    // A start always reports the second sync byte
    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == nbfs_pkg::EV_START) |-> (frame_pos == 11'd1))
        else $error("start result not at position one");

    // Idle results lie outside any frame
    a_idle_nokind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res == nbfs_pkg::EV_IDLE) |->
        (frame_kind == nbfs_pkg::KIND_NONE && frame_pos == 11'd0))
        else $error("idle result carries a frame kind or position");

    // Message id only on a binary completion
    a_msg_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && msg_id != 8'd0) |->
        (event_res == nbfs_pkg::EV_DONE && frame_kind == nbfs_pkg::KIND_BIN))
        else $error("message id outside a binary completion");

    // A taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !in_valid_reg) |=> !out_valid)
        else $error("result repeated after it was taken");

    // A queued byte must reach the frame logic once the output frees
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("queued byte did not produce a result");
`endif

endmodule
